@@ rtl/cau_pkg.sv @@
// Shared types, sizes and helpers of the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned ProdW     = 2 * DataWidth;
  localparam int unsigned SumW      = ProdW + 1;
  localparam int unsigned WideW     = SumW - FracBits;
  localparam int unsigned NumW      = SumW + FracBits;
  localparam int unsigned QuotW     = DataWidth + 1;
  localparam int unsigned DenW      = ProdW;
  localparam int unsigned HiW       = NumW - QuotW;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_ADDS  = 3'd4,
    OP_SUBS  = 3'd5,
    OP_SCALE = 3'd6,
    OP_DIVS  = 3'd7
  } op_e;

  // Item state as it travels down the divider chain
  typedef struct packed {
    logic                    valid;
    logic                    is_div;
    logic                    dz;
    logic                    neg_re;
    logic                    neg_im;
    logic                    ovf_re;
    logic                    ovf_im;
    logic [DenW-1:0]         rem_re;
    logic [DenW-1:0]         rem_im;
    logic [QuotW-1:0]        sh_re;
    logic [QuotW-1:0]        sh_im;
    logic [DenW-1:0]         den;
    logic signed [WideW-1:0] wre;
    logic signed [WideW-1:0] wim;
  } cell_t;

  typedef struct packed {
    logic                 ovf;
    logic [DataWidth-1:0] val;
  } sat_t;

  localparam logic [DataWidth-1:0] MaxPos = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic [DataWidth-1:0] MinNeg = {1'b1, {(DataWidth-1){1'b0}}};

  function automatic sat_t sat_wide(input logic signed [WideW-1:0] v);
    sat_t r;
    if (v > $signed(WideW'($signed(MaxPos)))) begin
      r.ovf = 1'b1;
      r.val = MaxPos;
    end else if (v < $signed(WideW'($signed(MinNeg)))) begin
      r.ovf = 1'b1;
      r.val = MinNeg;
    end else begin
      r.ovf = 1'b0;
      r.val = v[DataWidth-1:0];
    end
    return r;
  endfunction

  // q is a quotient magnitude, neg tells the sign of the result
  function automatic sat_t sat_quot(input logic [QuotW-1:0] q, input logic neg,
                                    input logic big);
    sat_t r;
    if (neg) begin
      if (big || (q > QuotW'(MinNeg))) begin
        r.ovf = 1'b1;
        r.val = MinNeg;
      end else begin
        r.ovf = 1'b0;
        r.val = DataWidth'(-q);
      end
    end else begin
      if (big || (q > QuotW'(MaxPos))) begin
        r.ovf = 1'b1;
        r.val = MaxPos;
      end else begin
        r.ovf = 1'b0;
        r.val = q[DataWidth-1:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cau_front.sv @@
// Front end: products, sums and divider setup over three pipeline stages.
`default_nettype none
module cau_front import cau_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [2:0]                  op_i,
  input  wire logic signed [DataWidth-1:0] ar_i,
  input  wire logic signed [DataWidth-1:0] ai_i,
  input  wire logic signed [DataWidth-1:0] br_i,
  input  wire logic signed [DataWidth-1:0] bi_i,
  output cell_t                            cell_o
);

  // stage A: products
  logic                        a_vld_q;
  op_e                         a_op_q;
  logic signed [DataWidth-1:0] a_ar_q, a_ai_q, a_br_q, a_bi_q;
  logic signed [ProdW-1:0]     a_rr_q, a_ii_q, a_ri_q, a_ir_q, a_bb_q, a_qq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_op_q <= op_e'(op_i);
      a_ar_q <= ar_i;
      a_ai_q <= ai_i;
      a_br_q <= br_i;
      a_bi_q <= bi_i;
      a_rr_q <= ProdW'(ar_i) * ProdW'(br_i);
      a_ii_q <= ProdW'(ai_i) * ProdW'(bi_i);
      a_ri_q <= ProdW'(ar_i) * ProdW'(bi_i);
      a_ir_q <= ProdW'(ai_i) * ProdW'(br_i);
      a_bb_q <= ProdW'(br_i) * ProdW'(br_i);
      a_qq_q <= ProdW'(bi_i) * ProdW'(bi_i);
    end
  end

  // stage B: sums
  logic                    b_vld_q, b_div_d, b_div_q, b_dneg_d, b_dneg_q;
  logic signed [SumW-1:0]  b_nre_d, b_nim_d, b_nre_q, b_nim_q, tre, tim;
  logic signed [WideW-1:0] b_wre_d, b_wim_d, b_wre_q, b_wim_q;
  logic [DenW-1:0]         b_den_d, b_den_q;
  logic signed [ProdW-1:0] bx;

  always_comb begin
    b_div_d  = 1'b0;
    b_dneg_d = 1'b0;
    b_nre_d  = '0;
    b_nim_d  = '0;
    b_wre_d  = '0;
    b_wim_d  = '0;
    b_den_d  = '0;
    tre      = '0;
    tim      = '0;
    bx       = ProdW'(a_br_q);
    unique case (a_op_q)
      OP_ADD: begin
        b_wre_d = WideW'(a_ar_q) + WideW'(a_br_q);
        b_wim_d = WideW'(a_ai_q) + WideW'(a_bi_q);
      end
      OP_SUB: begin
        b_wre_d = WideW'(a_ar_q) - WideW'(a_br_q);
        b_wim_d = WideW'(a_ai_q) - WideW'(a_bi_q);
      end
      OP_MUL: begin
        tre     = SumW'(a_rr_q) - SumW'(a_ii_q);
        tim     = SumW'(a_ri_q) + SumW'(a_ir_q);
        b_wre_d = WideW'(tre >>> FracBits);
        b_wim_d = WideW'(tim >>> FracBits);
      end
      OP_DIV: begin
        b_div_d = 1'b1;
        b_nre_d = SumW'(a_rr_q) + SumW'(a_ii_q);
        b_nim_d = SumW'(a_ir_q) - SumW'(a_ri_q);
        b_den_d = $unsigned(a_bb_q) + $unsigned(a_qq_q);
      end
      OP_ADDS: begin
        b_wre_d = WideW'(a_ar_q) + WideW'(a_br_q);
        b_wim_d = WideW'(a_ai_q);
      end
      OP_SUBS: begin
        b_wre_d = WideW'(a_ar_q) - WideW'(a_br_q);
        b_wim_d = WideW'(a_ai_q);
      end
      OP_SCALE: begin
        b_wre_d = WideW'(a_rr_q >>> FracBits);
        b_wim_d = WideW'(a_ir_q >>> FracBits);
      end
      OP_DIVS: begin
        b_div_d  = 1'b1;
        b_nre_d  = SumW'(a_ar_q);
        b_nim_d  = SumW'(a_ai_q);
        b_dneg_d = a_br_q[DataWidth-1];
        b_den_d  = $unsigned(b_dneg_d ? -bx : bx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_div_q  <= b_div_d;
      b_dneg_q <= b_dneg_d;
      b_nre_q  <= b_nre_d;
      b_nim_q  <= b_nim_d;
      b_wre_q  <= b_wre_d;
      b_wim_q  <= b_wim_d;
      b_den_q  <= b_den_d;
    end
  end

  // stage C: numerator magnitudes, range precheck, chain entry
  logic [SumW-1:0] mag_re, mag_im;
  logic [NumW-1:0] num_re, num_im;
  logic            c_vld_q;
  cell_t           c_d, c_q;

  always_comb begin
    mag_re        = $unsigned(b_nre_q[SumW-1] ? -b_nre_q : b_nre_q);
    mag_im        = $unsigned(b_nim_q[SumW-1] ? -b_nim_q : b_nim_q);
    num_re        = NumW'(mag_re) << FracBits;
    num_im        = NumW'(mag_im) << FracBits;
    c_d.valid     = b_vld_q;
    c_d.is_div    = b_div_q;
    c_d.dz        = b_div_q && (b_den_q == '0);
    c_d.neg_re    = b_nre_q[SumW-1] ^ b_dneg_q;
    c_d.neg_im    = b_nim_q[SumW-1] ^ b_dneg_q;
    // quotient of 2^QuotW or more always saturates
    c_d.ovf_re    = NumW'(num_re[NumW-1:QuotW]) >= NumW'(b_den_q);
    c_d.ovf_im    = NumW'(num_im[NumW-1:QuotW]) >= NumW'(b_den_q);
    c_d.rem_re    = DenW'(num_re[NumW-1:QuotW]);
    c_d.rem_im    = DenW'(num_im[NumW-1:QuotW]);
    c_d.sh_re     = num_re[QuotW-1:0];
    c_d.sh_im     = num_im[QuotW-1:0];
    c_d.den       = b_den_q;
    c_d.wre       = b_wre_q;
    c_d.wim       = b_wim_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      c_vld_q <= c_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  always_comb begin
    cell_o       = c_q;
    cell_o.valid = c_vld_q;
  end

endmodule
`default_nettype wire

@@ rtl/cau_div_cell.sv @@
// One restoring-division step on both lanes; passes the item to the next cell.
`default_nettype none
module cau_div_cell import cau_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire cell_t cell_i,
  output cell_t      cell_o
);

  logic [DenW:0] t_re, t_im, dx;
  logic          ge_re, ge_im;
  logic          vld_q;
  cell_t         c_d, c_q;

  always_comb begin
    dx       = {1'b0, cell_i.den};
    t_re     = {cell_i.rem_re, cell_i.sh_re[QuotW-1]};
    t_im     = {cell_i.rem_im, cell_i.sh_im[QuotW-1]};
    ge_re    = t_re >= dx;
    ge_im    = t_im >= dx;
    c_d      = cell_i;
    c_d.rem_re = ge_re ? DenW'(t_re - dx) : DenW'(t_re);
    c_d.rem_im = ge_im ? DenW'(t_im - dx) : DenW'(t_im);
    c_d.sh_re  = {cell_i.sh_re[QuotW-2:0], ge_re};
    c_d.sh_im  = {cell_i.sh_im[QuotW-2:0], ge_im};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= c_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  always_comb begin
    cell_o       = c_q;
    cell_o.valid = vld_q;
  end

endmodule
`default_nettype wire

@@ rtl/complex_arithmetic_unit_core.sv @@
// Complex Q16.16 ALU: add, sub, mul, div and their scalar forms, fully pipelined.
// Takes one item per clock while s_axis_tready is high and returns one result per
// item, in order. Every opcode passes 3 front stages, 33 divider cells and
// 1 output register; the 33 cells form the restoring divider chain, one quotient
// bit per cell. A stall on the result side holds the whole pipeline, so
// s_axis_tready follows m_axis_tready while the output register is full.
// Results saturate to the 32-bit signed range and raise overflow; a zero divisor
// gives zero results with div_zero set.
`default_nettype none
module complex_arithmetic_unit_core import cau_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // a_re, a_im, b_re, b_im
  input  wire logic [2:0]   s_axis_tuser,  // opcode
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // res_re, res_im
  output logic [1:0]        m_axis_tuser   // overflow, div_zero
);

  logic  en;
  cell_t chain [QuotW+1];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  cau_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s_axis_tvalid),
    .op_i   (s_axis_tuser),
    .ar_i   ($signed(s_axis_tdata[31:0])),
    .ai_i   ($signed(s_axis_tdata[63:32])),
    .br_i   ($signed(s_axis_tdata[95:64])),
    .bi_i   ($signed(s_axis_tdata[127:96])),
    .cell_o (chain[0])
  );

  for (genvar g = 0; g < QuotW; g++) begin : g_cell
    cau_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .cell_i(chain[g]),
      .cell_o(chain[g+1])
    );
  end

  cell_t                last;
  sat_t                 s_re, s_im;
  logic [DataWidth-1:0] re_d, im_d, re_q, im_q;
  logic                 ovf_d, ovf_q, dz_q, vld_q;

  always_comb begin
    last = chain[QuotW];
    if (last.is_div) begin
      s_re = sat_quot(last.sh_re, last.neg_re, last.ovf_re);
      s_im = sat_quot(last.sh_im, last.neg_im, last.ovf_im);
    end else begin
      s_re = sat_wide(last.wre);
      s_im = sat_wide(last.wim);
    end
    if (last.dz) begin
      re_d  = '0;
      im_d  = '0;
      ovf_d = 1'b0;
    end else begin
      re_d  = s_re.val;
      im_d  = s_im.val;
      ovf_d = s_re.ovf || s_im.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      re_q  <= re_d;
      im_q  <= im_d;
      ovf_q <= ovf_d;
      dz_q  <= last.dz;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {im_q, re_q};
  assign m_axis_tuser  = {dz_q, ovf_q};

endmodule
`default_nettype wire
